// ===== hdl/ftsf_pkg.sv =====
// Package: widths and constants for the fixed/single-float converter.
package ftsf_pkg;
  localparam int IntBits   = 16;
  localparam int FracBits  = 10;
  localparam int TotalBits = IntBits + FracBits;
  localparam int MantBits  = 23;
  localparam int ExpBias   = 127;
  localparam int ExpBits   = 8;
  localparam int PosBits   = 5;

  // Conversion direction codes on in_mode.
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef logic [TotalBits-1:0] mag_t;
  typedef logic [31:0]          word_t;

  typedef struct packed {
    logic  mode;
    logic  sign;
    mag_t  magnitude;
    word_t float_word;
  } item_t;

  typedef struct packed {
    word_t float_result;
    logic  fixed_sign;
    mag_t  fixed_magnitude;
    logic  out_of_range;
  } result_t;
endpackage

// ===== hdl/ftsf_encode.sv =====
// Encoder: fixed point magnitude to single word.
module ftsf_encode (
  input  logic          sign,
  input  ftsf_pkg::mag_t magnitude,
  output ftsf_pkg::word_t word
);
  import ftsf_pkg::*;

  logic [PosBits-1:0]  pos;
  logic [MantBits:0]   aligned;
  logic [ExpBits-1:0]  ex;

  always_comb begin
    pos = '0;
    for (int i = 0; i < TotalBits; i++) begin
      if (magnitude[i]) pos = PosBits'(i);
    end
  end

  always_comb begin
    if (int'(pos) <= MantBits)
      aligned = (MantBits+1)'(magnitude) << (PosBits'(MantBits) - pos);
    else
      aligned = (MantBits+1)'(magnitude >> (pos - PosBits'(MantBits)));
    ex = ExpBits'(int'(pos) - FracBits + ExpBias);
    if (magnitude == '0)
      word = {sign, 31'd0};
    else
      word = {sign, ex, aligned[MantBits-1:0]};
  end
endmodule

// ===== hdl/ftsf_decode.sv =====
// Decoder: single word to fixed point magnitude with saturation.
module ftsf_decode (
  input  ftsf_pkg::word_t word,
  output ftsf_pkg::mag_t  magnitude,
  output logic            sat
);
  import ftsf_pkg::*;

  logic [ExpBits-1:0]  e;
  logic signed [9:0]   shift;
  logic [MantBits:0]   sig;
  logic [MantBits+TotalBits:0] wide;

  assign e   = word[30:23];
  assign sig = {1'b1, word[MantBits-1:0]};
  assign shift = 10'(signed'({2'b00, e})) - 10'(ExpBias + MantBits - FracBits);

  always_comb begin
    sat  = 1'b0;
    wide = '0;
    magnitude = '0;
    if (e == '0) begin
      magnitude = '0;
    end else if (e == '1 || (shift + 10'(MantBits)) >= 10'(TotalBits)) begin
      sat = 1'b1;
      magnitude = '1;
    end else if (shift >= 0) begin
      wide = (MantBits+TotalBits+1)'(sig) << shift[4:0];
      magnitude = wide[TotalBits-1:0];
    end else if (shift > -10'sd32) begin
      wide = (MantBits+TotalBits+1)'(sig >> 5'(-shift));
      magnitude = wide[TotalBits-1:0];
    end
  end
endmodule

// ===== hdl/fixed_to_single_float_converter.sv =====
// Top level: registered fixed point <-> single float converter.
// Usage:
//   Pulse start with in_mode and the payload; busy is always low, so a
//   transaction is taken at every edge with start high.
//   Mode 0 encodes in_sign/in_magnitude (Q16.10) into out_float_result.
//   Mode 1 decodes in_float_word into out_fixed_sign/out_fixed_magnitude,
//   with out_of_range flagging saturation; unused outputs read zero.
// Pipeline: inputs and start are registered (item_r, vld_r), the logic
//   runs, and results and valid are registered again (res_r, out_vld_r);
//   out_valid rises together with the registered result.
// Throughput: one transaction per cycle, set by the single pass through
//   the leading-one detector and barrel shifters.
// Reset: synchronous active-low rst_n clears the valid pipeline; the
//   data registers item_r and res_r are not reset.
// Results show for exactly one cycle; the receiver cannot stall.
module fixed_to_single_float_converter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_mode,
  input  logic            in_sign,
  input  ftsf_pkg::mag_t  in_magnitude,
  input  ftsf_pkg::word_t in_float_word,
  output logic            out_valid,
  output ftsf_pkg::word_t out_float_result,
  output logic            out_fixed_sign,
  output ftsf_pkg::mag_t  out_fixed_magnitude,
  output logic            out_of_range
);
  import ftsf_pkg::*;

  item_t   item_r;
  logic    vld_r, out_vld_r;
  result_t res_nxt, res_r;
  word_t   enc_word;
  mag_t    dec_mag;
  logic    dec_sat;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= start;
      out_vld_r <= vld_r;
    end
    item_r <= '{in_mode, in_sign, in_magnitude, in_float_word};
    res_r  <= res_nxt;
  end

  ftsf_encode u_enc (.sign(item_r.sign), .magnitude(item_r.magnitude), .word(enc_word));
  ftsf_decode u_dec (.word(item_r.float_word), .magnitude(dec_mag), .sat(dec_sat));

  always_comb begin
    res_nxt = '0;
    if (item_r.mode == ModeEncode) begin
      res_nxt.float_result = enc_word;
    end else begin
      res_nxt.fixed_sign      = item_r.float_word[31];
      res_nxt.fixed_magnitude = dec_mag;
      res_nxt.out_of_range    = dec_sat;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_float_result    = res_r.float_result;
  assign out_fixed_sign      = res_r.fixed_sign;
  assign out_fixed_magnitude = res_r.fixed_magnitude;
  assign out_of_range        = res_r.out_of_range;
endmodule

// ===== bench/tb_top.sv =====
// Testbench for the fixed point <-> single float converter: directed and random transactions.
module tb_top;
  import ftsf_pkg::*;

  localparam int MaxMismatchPrints = 10;
  localparam int CycleLimit        = 200000;
  localparam int DrainCycles       = 8;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  in_mode = 1'b0;
  logic  in_sign = 1'b0;
  mag_t  in_magnitude = '0;
  word_t in_float_word = '0;
  logic  out_valid;
  word_t out_float_result;
  logic  out_fixed_sign;
  mag_t  out_fixed_magnitude;
  logic  out_of_range;

  // Expected conversions, oldest first.
  result_t conv_expected_q[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      encode_sent = 0;
  int      decode_sent = 0;
  int      results_seen = 0;
  bit      allow_idle = 1'b1;

  fixed_to_single_float_converter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_sign            (in_sign),
    .in_magnitude       (in_magnitude),
    .in_float_word      (in_float_word),
    .out_valid          (out_valid),
    .out_float_result   (out_float_result),
    .out_fixed_sign     (out_fixed_sign),
    .out_fixed_magnitude(out_fixed_magnitude),
    .out_of_range       (out_of_range)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung pipeline must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Predict one conversion result from the transaction fields.
  function automatic result_t predict_conversion(logic mode, logic sgn, mag_t mag,
                                                 word_t word);
    result_t r;
    int      lead;
    int      shift;
    logic [7:0]  ex;
    logic [23:0] sig;
    logic [63:0] wide;
    r = '0;
    lead = -1;
    if (mode == ModeEncode) begin
      if (mag == '0) begin
        r.float_result = {sgn, 31'b0};
      end else begin
        for (int i = 0; i < TotalBits; i++)
          if (mag[i]) lead = i;
        ex = 8'(lead - FracBits + ExpBias);
        if (lead <= MantBits) wide = 64'(mag) << (MantBits - lead);
        else wide = 64'(mag) >> (lead - MantBits);
        r.float_result = {sgn, ex, wide[MantBits-1:0]};
      end
    end else begin
      r.fixed_sign = word[31];
      ex = word[30:23];
      if (ex == 8'd0) begin
        r.fixed_magnitude = '0;
      end else if (ex == 8'hFF) begin
        r.fixed_magnitude = '1;
        r.out_of_range = 1'b1;
      end else begin
        shift = int'(ex) - ExpBias - MantBits + FracBits;
        if (MantBits + shift >= TotalBits) begin
          r.fixed_magnitude = '1;
          r.out_of_range = 1'b1;
        end else begin
          sig = {1'b1, word[22:0]};
          // Below the saturation bound the left shift stays under 3.
          if (shift >= 0) wide = 64'(sig) << shift;
          else if (-shift >= 64) wide = '0;
          else wide = 64'(sig) >> (-shift);
          r.fixed_magnitude = wide[TotalBits-1:0];
        end
      end
    end
    return r;
  endfunction

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (conv_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxMismatchPrints)
          $display("Unexpected result transaction: float %h mag %h",
                   out_float_result, out_fixed_magnitude);
      end else begin
        exp_r = conv_expected_q.pop_front();
        if (out_float_result !== exp_r.float_result ||
            out_fixed_sign !== exp_r.fixed_sign ||
            out_fixed_magnitude !== exp_r.fixed_magnitude ||
            out_of_range !== exp_r.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= MaxMismatchPrints)
            $display("Mismatch: exp float %h sign %b mag %h oor %b, got %h %b %h %b",
                     exp_r.float_result, exp_r.fixed_sign, exp_r.fixed_magnitude,
                     exp_r.out_of_range, out_float_result, out_fixed_sign,
                     out_fixed_magnitude, out_of_range);
        end
      end
    end
  end

  // Send one transaction; optional random idle burst first.
  task automatic send_conversion(logic mode, logic sgn, mag_t mag, word_t word);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= mode;
    in_sign       <= sgn;
    in_magnitude  <= mag;
    in_float_word <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: record expectation.
    conv_expected_q.push_back(predict_conversion(mode, sgn, mag, word));
    if (mode == ModeEncode) encode_sent++;
    else decode_sent++;
  endtask

  task automatic release_start();
    start <= 1'b0;
  endtask

  // Wait until all expected results have arrived.
  task automatic drain_results();
    release_start();
    while (conv_expected_q.size() != 0) @(posedge clk);
  endtask

  // Encode extremes: zero both signs, one LSB, one, full scale, every fifth power of two.
  task automatic test_encode_directed();
    send_conversion(ModeEncode, 1'b0, '0, '0);
    send_conversion(ModeEncode, 1'b1, '0, '1);
    send_conversion(ModeEncode, 1'b0, mag_t'(1), '0);
    send_conversion(ModeEncode, 1'b1, mag_t'(1) << FracBits, '0);
    send_conversion(ModeEncode, 1'b0, '1, '0);
    send_conversion(ModeEncode, 1'b1, '1, '1);
    send_conversion(ModeEncode, 1'b0, mag_t'(26'h2AAAAAA), '0);
    send_conversion(ModeEncode, 1'b1, mag_t'(26'h1555555), '0);
    for (int b = 0; b < TotalBits; b += 5)
      send_conversion(ModeEncode, b[0], mag_t'(1) << b, '0);
  endtask

  // Decode special cases: zero, subnormal, inf, NaN, overflow, underflow.
  task automatic test_decode_directed();
    send_conversion(ModeDecode, 1'b0, '0, 32'h0000_0000);
    send_conversion(ModeDecode, 1'b1, '1, 32'h8000_0000);
    send_conversion(ModeDecode, 1'b0, '0, 32'h007F_FFFF);
    send_conversion(ModeDecode, 1'b0, '0, 32'h7F80_0000);
    send_conversion(ModeDecode, 1'b0, '0, 32'hFFFF_FFFF);
    send_conversion(ModeDecode, 1'b0, '0, 32'h477F_FFFF);
    send_conversion(ModeDecode, 1'b0, '0, 32'h4780_0000);
    send_conversion(ModeDecode, 1'b1, '0, 32'h3F80_0000);
    send_conversion(ModeDecode, 1'b0, '0, 32'h3A80_0000);
    send_conversion(ModeDecode, 1'b0, '0, 32'h3A7F_FFFF);
    send_conversion(ModeDecode, 1'b0, '0, 32'h0080_0000);
    drain_results();
  endtask

  // Random mix: in-range floats, raw words and raw magnitudes.
  task automatic test_random_mix(int count);
    mag_t  mag;
    word_t word;
    int    pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      mag = mag_t'($urandom);
      if (pick < 2) mag = mag >> $urandom_range(TotalBits - 1);
      word = $urandom;
      // Mostly keep exponents near the representable range.
      if (pick >= 5 && pick < 9) word[30:23] = 8'($urandom_range(100, 145));
      if (allow_idle && n == count / 2) begin
        drain_results();  // full pause mid-stream
      end
      send_conversion(pick < 4 ? ModeEncode : ModeDecode, 1'($urandom_range(1)), mag, word);
    end
  endtask

  // Back-to-back stream with no idle cycles.
  task automatic test_back_to_back(int count);
    allow_idle = 1'b0;
    test_random_mix(count);
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_random_mix(400);
    test_back_to_back(100);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d encode and %0d decode transactions, %0d results checked",
             encode_sent, decode_sent, results_seen);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0 && conv_expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
